/* hdl/pes_pkg.sv */
`timescale 1ns / 1ps

package pes_pkg;

  // Default sample width: phase, shape, mod and the output sample.
  localparam int SAMPLE_BITS_DEF = 16;

  // Which segment of the waveform a sample falls into.
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_LOW    = 2'd0;  // at or past the pulse width
  localparam cls_t CLS_ATTACK = 2'd1;  // concave rise at the start of the pulse
  localparam cls_t CLS_DECAY  = 2'd2;  // convex fall at the end of the pulse
  localparam cls_t CLS_HIGH   = 2'd3;  // plateau between the ramps

  // Control that travels with each pipeline slot from stage 7 on.
  typedef struct packed {
    logic valid;
    cls_t cls;
  } tag_t;

endpackage

/* hdl/pes_divider.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Computes (num << W) / den for num < den, so the quotient fits in W bits.
module pes_divider #(
  parameter int W = pes_pkg::SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  pes_pkg::tag_t   tag_in,
  input  logic [W-1:0]    num_in,
  input  logic [W-1:0]    den_in,
  output pes_pkg::tag_t   tag_out,
  output logic [W-1:0]    quo_out
);
  import pes_pkg::*;

  tag_t         tag_r [W];
  logic [W-1:0] rem_r [W];
  logic [W-1:0] quo_r [W];
  logic [W-1:0] den_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    tag_t         tag_src;
    logic [W-1:0] rem_src;
    logic [W-1:0] quo_src;
    logic [W-1:0] den_src;
    logic [W:0]   trial;
    logic [W:0]   diff;

    if (k == 0) begin : g_first
      assign tag_src = tag_in;
      assign rem_src = num_in;
      assign quo_src = '0;
      assign den_src = den_in;
    end else begin : g_next
      assign tag_src = tag_r[k-1];
      assign rem_src = rem_r[k-1];
      assign quo_src = quo_r[k-1];
      assign den_src = den_r[k-1];
    end

    assign trial = {rem_src, 1'b0};
    assign diff  = trial - {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= tag_src;
      end
    end

    // A clear sign bit means the shifted remainder reached the divisor.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        quo_r[k] <= {quo_src[W-2:0], ~diff[W]};
        den_r[k] <= den_src;
      end
    end
  end

  assign tag_out = tag_r[W-1];
  assign quo_out = quo_r[W-1];

endmodule

/* hdl/pwm_envelope_shaper.sv */
`timescale 1ns / 1ps

// Channel  Direction  Beat contents (lowest bits first)
// in_      slave      phase, shape_value, mod_value (SAMPLE_BITS each, zero padded)
// out_     master     sample (SAMPLE_BITS, zero padded)
//
// One beat is taken every clock cycle while in_tready is high. A result passes
// the stage registers, the quotient divider, which resolves one quotient bit per
// pipeline stage, the square stage and the output register.
// rst_n is synchronous and active low; it clears only the valid bits and the slot tags.
// When out_tready is held low the last result sits in the output register and
// one more in a skid register; only then does in_tready drop and the whole
// pipeline freeze, so no beat is lost or repeated.
module pwm_envelope_shaper #(
  parameter int SAMPLE_BITS = pes_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // phase, shape_value, mod_value
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // sample
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);
  import pes_pkg::*;

  localparam int B     = SAMPLE_BITS;
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  // Constants in phase units (Q0.B), rounded to nearest.
  localparam longint unsigned ONE_L = 64'd1 << B;
  localparam longint unsigned K_L   = (48 * ONE_L + 50) / 100;
  localparam longint unsigned WLO_L = (2 * ONE_L + 50) / 100;
  localparam longint unsigned WHI_L = (98 * ONE_L + 50) / 100;

  localparam logic [B-1:0] K_C    = B'(K_L);
  localparam logic [B-1:0] WLO_C  = B'(WLO_L);
  localparam logic [B-1:0] WHI_C  = B'(WHI_L);
  localparam logic [B-1:0] HALF_C = {1'b1, {(B-1){1'b0}}};  // also the code of -1.0
  localparam logic [B-1:0] SAT_C  = {1'b0, {(B-1){1'b1}}};  // largest positive sample

  // The whole pipeline moves unless the skid register is holding a result.
  logic en;
  logic skid_v_r;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // Input fields.
  logic [B-1:0]        in_phase;
  logic signed [B-1:0] in_shape;
  logic [B-1:0]        in_mod;
  assign in_phase = in_tdata[B-1:0];
  assign in_shape = in_tdata[2*B-1:B];
  assign in_mod   = in_tdata[3*B-1:2*B];

  // Stage 1: shape times 0.48.
  logic signed [B:0]   k_s;
  logic signed [2*B:0] sk_nxt;
  assign k_s    = {1'b0, K_C};
  assign sk_nxt = in_shape * k_s;

  logic                s1_v_r;
  logic [B-1:0]        s1_p_r;
  logic [B-1:0]        s1_m_r;
  logic signed [2*B:0] s1_sk_r;

  // Stage 2: width = 0.5 + shape*0.48, the scaling truncated toward zero, then
  // clamped. The mod magnitude and the attack share (HALF + mod) are formed
  // alongside.
  logic signed [B+1:0] tq;
  logic                round_up;
  logic signed [B+2:0] wi;
  logic [B-1:0]        w_nxt;
  logic [B-1:0]        mag_nxt;
  logic [B-1:0]        hm_nxt;

  assign tq       = s1_sk_r[2*B:B-1];
  assign round_up = s1_sk_r[2*B] & (|s1_sk_r[B-2:0]);
  assign wi       = $signed({3'b000, HALF_C}) + tq + $signed({{(B+2){1'b0}}, round_up});

  always_comb begin
    if (wi < $signed({3'b000, WLO_C})) begin
      w_nxt = WLO_C;
    end else if (wi > $signed({3'b000, WHI_C})) begin
      w_nxt = WHI_C;
    end else begin
      w_nxt = wi[B-1:0];
    end
  end

  assign mag_nxt = s1_m_r[B-1] ? (~s1_m_r + 1'b1) : s1_m_r;
  assign hm_nxt  = {~s1_m_r[B-1], s1_m_r[B-2:0]};

  logic         s2_v_r;
  logic [B-1:0] s2_p_r;
  logic [B-1:0] s2_w_r;
  logic [B-1:0] s2_mag_r;
  logic [B-1:0] s2_hm_r;

  // Stage 3: |mod| times width; the gate test runs in parallel.
  logic [2*B-1:0] mw_nxt;
  assign mw_nxt = s2_mag_r * s2_w_r;

  logic           s3_v_r;
  logic [B-1:0]   s3_p_r;
  logic [B-1:0]   s3_w_r;
  logic [B-1:0]   s3_hm_r;
  logic [2*B-1:0] s3_mw_r;
  logic           s3_gate_r;

  // Stage 4: the ramp length is never above the width, so it fits in B bits.
  logic [B-1:0]   ramp_nxt;
  logic [2*B-1:0] ra_nxt;
  assign ramp_nxt = s3_mw_r[2*B-2:B-1];
  assign ra_nxt   = ramp_nxt * s3_hm_r;

  logic           s4_v_r;
  logic [B-1:0]   s4_p_r;
  logic [B-1:0]   s4_w_r;
  logic [B-1:0]   s4_ramp_r;
  logic [2*B-1:0] s4_ra_r;
  logic           s4_gate_r;

  // Stage 5: split the ramp into attack and decay lengths.
  logic [B-1:0] attack_nxt;
  logic [B-1:0] decay_nxt;
  assign attack_nxt = s4_ra_r[2*B-1:B];
  assign decay_nxt  = s4_ramp_r - attack_nxt;

  logic         s5_v_r;
  logic [B-1:0] s5_p_r;
  logic [B-1:0] s5_w_r;
  logic [B-1:0] s5_attack_r;
  logic [B-1:0] s5_decay_r;
  logic         s5_gate_r;

  // Stage 6: start of the decay, and whether the phase is still in the attack.
  logic [B-1:0] pe_nxt;
  assign pe_nxt = s5_w_r - s5_decay_r;

  logic         s6_v_r;
  logic [B-1:0] s6_p_r;
  logic [B-1:0] s6_pe_r;
  logic [B-1:0] s6_attack_r;
  logic [B-1:0] s6_decay_r;
  logic         s6_gate_r;
  logic         s6_att_r;

  // Stage 7: pick the segment and set up the shared division. Only the ramp
  // segments use the quotient, and a zero-length segment is never chosen.
  tag_t         tag_nxt;
  logic [B-1:0] num_nxt;
  logic [B-1:0] den_nxt;

  always_comb begin
    tag_nxt.valid = s6_v_r;
    num_nxt       = s6_p_r;
    den_nxt       = s6_attack_r;
    if (s6_gate_r) begin
      tag_nxt.cls = CLS_LOW;
    end else if (s6_att_r) begin
      tag_nxt.cls = CLS_ATTACK;
    end else if (s6_p_r >= s6_pe_r) begin
      tag_nxt.cls = CLS_DECAY;
      num_nxt     = s6_p_r - s6_pe_r;
      den_nxt     = s6_decay_r;
    end else begin
      tag_nxt.cls = CLS_HIGH;
    end
  end

  tag_t         s7_tag_r;
  logic [B-1:0] s7_num_r;
  logic [B-1:0] s7_den_r;

  // Divider: B stages.
  tag_t         div_tag;
  logic [B-1:0] div_quo;

  pes_divider #(
    .W(B)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (s7_tag_r),
    .num_in  (s7_num_r),
    .den_in  (s7_den_r),
    .tag_out (div_tag),
    .quo_out (div_quo)
  );

  // Square stage: both ramps square (1 - quotient). A zero quotient stands for
  // a full-scale term and is flagged instead of squared.
  logic [B-1:0]   dq;
  logic [2*B-1:0] sq_nxt;
  assign dq     = ~div_quo + 1'b1;
  assign sq_nxt = dq * dq;

  tag_t           pa_tag_r;
  logic           pa_zero_r;
  logic [2*B-1:0] pa_sq_r;

  // Final mapping to Q1.(B-1). A level of +1 saturates.
  logic [B-1:0] hi;
  logic [B-1:0] sample_nxt;
  assign hi = pa_sq_r[2*B-1:B];

  always_comb begin
    unique case (pa_tag_r.cls)
      CLS_LOW: begin
        sample_nxt = HALF_C;
      end
      CLS_HIGH: begin
        sample_nxt = SAT_C;
      end
      CLS_ATTACK: begin
        // Level 1 - hi, i.e. HALF - hi in sample codes.
        if (pa_zero_r) begin
          sample_nxt = HALF_C;
        end else if (hi == '0) begin
          sample_nxt = SAT_C;
        end else begin
          sample_nxt = HALF_C - hi;
        end
      end
      CLS_DECAY: begin
        // Level hi - 1, i.e. hi with its top bit flipped.
        if (pa_zero_r) begin
          sample_nxt = SAT_C;
        end else begin
          sample_nxt = {~hi[B-1], hi[B-2:0]};
        end
      end
    endcase
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      s5_v_r   <= 1'b0;
      s6_v_r   <= 1'b0;
      s7_tag_r <= '0;
      pa_tag_r <= '0;
    end else if (en) begin
      s1_v_r   <= in_tvalid;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      s4_v_r   <= s3_v_r;
      s5_v_r   <= s4_v_r;
      s6_v_r   <= s5_v_r;
      s7_tag_r <= tag_nxt;
      pa_tag_r <= div_tag;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r      <= in_phase;
      s1_m_r      <= in_mod;
      s1_sk_r     <= sk_nxt;

      s2_p_r      <= s1_p_r;
      s2_w_r      <= w_nxt;
      s2_mag_r    <= mag_nxt;
      s2_hm_r     <= hm_nxt;

      s3_p_r      <= s2_p_r;
      s3_w_r      <= s2_w_r;
      s3_hm_r     <= s2_hm_r;
      s3_mw_r     <= mw_nxt;
      s3_gate_r   <= (s2_p_r >= s2_w_r);

      s4_p_r      <= s3_p_r;
      s4_w_r      <= s3_w_r;
      s4_ramp_r   <= ramp_nxt;
      s4_ra_r     <= ra_nxt;
      s4_gate_r   <= s3_gate_r;

      s5_p_r      <= s4_p_r;
      s5_w_r      <= s4_w_r;
      s5_attack_r <= attack_nxt;
      s5_decay_r  <= decay_nxt;
      s5_gate_r   <= s4_gate_r;

      s6_p_r      <= s5_p_r;
      s6_pe_r     <= pe_nxt;
      s6_attack_r <= s5_attack_r;
      s6_decay_r  <= s5_decay_r;
      s6_gate_r   <= s5_gate_r;
      s6_att_r    <= (s5_p_r < s5_attack_r);

      s7_num_r    <= num_nxt;
      s7_den_r    <= den_nxt;

      pa_zero_r   <= (div_quo == '0);
      pa_sq_r     <= sq_nxt;
    end
  end

  // Output register plus skid register. A finished result goes to the skid
  // register only when the output register is full and stalled.
  logic         out_v_r;
  logic [B-1:0] out_d_r;
  logic [B-1:0] skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (pa_tag_r.valid) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_r <= skid_d_r;
      end
    end else if (pa_tag_r.valid) begin
      if (out_v_r && !out_tready) begin
        skid_d_r <= sample_nxt;
      end else begin
        out_d_r <= sample_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(out_d_r);

endmodule

/* hdl/pes_checker.sv */
`timescale 1ns / 1ps

module pes_checker #(
  parameter int SAMPLE_BITS = pes_pkg::SAMPLE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);
  import pes_pkg::*;

  // Pipeline slots, the divider stages, the square stage, output and skid.
  localparam int MAX_INFL = SAMPLE_BITS + 10;
  localparam int CW       = $clog2(MAX_INFL + 2);

  logic          in_acc;
  logic          out_acc;
  logic [CW-1:0] count_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_r + CW'(in_acc) - CW'(out_acc);
    end
  end

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed or vanished");

  // Every result beat belongs to an input beat taken earlier.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> count_r != '0)
    else $error("output beat without a matching input beat");

  // The pipeline never holds more beats than it has slots.
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> count_r < CW'(MAX_INFL))
    else $error("more beats in flight than pipeline slots");

  // Input back-pressure starts only from a stalled output.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("in_tready dropped without an output stall");

endmodule

bind pwm_envelope_shaper pes_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pes_checker (.*);

/* tb/sample_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the envelope shaper, predicts each output sample
// from the accepted input beat and compares results in order.
module sample_checker #(
  parameter int SB   = pes_pkg::SAMPLE_BITS_DEF,
  parameter int IN_W = ((3*SB+7)/8)*8,
  parameter int OUT_W = ((SB+7)/8)*8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  // phase, shape_value, mod_value
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  // sample
  input  logic [OUT_W-1:0] out_tdata,
  output int               mismatches,
  output int               outstanding,
  output int               results_checked
);

  localparam longint ONE    = longint'(1) << SB;
  localparam longint HALF   = longint'(1) << (SB - 1);
  localparam longint GAIN_K = (48 * ONE + 50) / 100;
  localparam longint W_MIN  = (2 * ONE + 50) / 100;
  localparam longint W_MAX  = (98 * ONE + 50) / 100;

  logic [SB-1:0] expected_samples[$];
  logic [SB-1:0] want;

  // Pulse gate with a quadratic attack, a plateau and a quadratic decay.
  function automatic logic [SB-1:0] envelope_level(logic [SB-1:0] ph,
                                                   logic [SB-1:0] sh,
                                                   logic [SB-1:0] md);
    longint p, s, m, w, mag, ramp, atk, dcy, pe, x, d, t, q, y, lvl;
    p = ph;
    s = $signed(sh);
    m = $signed(md);
    w = HALF + (s * GAIN_K) / HALF;
    if (w < W_MIN) w = W_MIN;
    if (w > W_MAX) w = W_MAX;
    if (p >= w) begin
      lvl = -HALF;
    end else begin
      mag  = (m < 0) ? -m : m;
      ramp = (mag * w) / HALF;
      atk  = (ramp * (HALF + m)) / ONE;
      dcy  = ramp - atk;
      pe   = w - dcy;
      if (p < atk) begin
        x = (p * ONE) / atk;
        if (x == 0) begin
          t = 0;
        end else begin
          d = ONE - x;
          t = ONE - (d * d) / ONE;
        end
        lvl = -HALF + t;
      end else if (p >= pe) begin
        q = ((p - pe) * ONE) / dcy;
        if (q == 0) begin
          t = ONE;
        end else begin
          y = ONE - q;
          t = (y * y) / ONE;
        end
        lvl = -HALF + t;
      end else begin
        lvl = HALF - 1;
      end
    end
    // The top of a ramp reaches +1, which does not fit.
    if (lvl > HALF - 1) lvl = HALF - 1;
    return lvl[SB-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches      <= 0;
      outstanding     <= 0;
      results_checked <= 0;
    end else begin
      // Results are matched before the new beat is queued.
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample: no result expected, got %0d", $signed(out_tdata[SB-1:0]));
          mismatches <= mismatches + 1;
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_tdata[SB-1:0]) begin
            $error("sample mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(out_tdata[SB-1:0]));
            mismatches <= mismatches + 1;
          end
        end
        results_checked <= results_checked + 1;
      end
      if (in_tvalid && in_tready)
        expected_samples.push_back(envelope_level(in_tdata[SB-1:0],
                                                  in_tdata[2*SB-1:SB],
                                                  in_tdata[3*SB-1:2*SB]));
      outstanding <= expected_samples.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Top of the envelope shaper bench. This module only produces traffic on the
// two streams and reports the verdict; all prediction and comparison lives in
// the sample checker instantiated beside the block.
module tb;

  localparam int SB    = pes_pkg::SAMPLE_BITS_DEF;
  localparam int IN_W  = ((3*SB+7)/8)*8;
  localparam int OUT_W = ((SB+7)/8)*8;

  // Tail wait: the block's answer delay, with some slack on top.
  localparam int LATENCY     = SB + 9;
  localparam int TAIL_CYCLES = LATENCY + 16;

  // Long output stall, well beyond the pipeline depth, so the input stalls.
  localparam int HOLD_CYCLES = 400;

  localparam int RANDOM_BEATS = 1500;
  localparam int MAX_GAP      = 17;

  // Gain of the shape input on the pulse width, and the width clamp, used
  // only to aim random phases at the falling edge of the pulse.
  localparam int WIDTH_GAIN = 31457;
  localparam int WIDTH_MIN  = 1311;
  localparam int WIDTH_MAX  = 64225;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  // phase, shape_value, mod_value
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  // sample
  logic [OUT_W-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int results_checked;

  // When set, both sides stop idling between beats.
  bit steady_run;
  // Raised by the sender; the receiver clears it after its long stall.
  bit hold_off_req;

  int beats_sent;
  int directed_beats;

  pwm_envelope_shaper #(
    .SAMPLE_BITS(SB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sample_checker #(
    .SB(SB)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  // 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offers one beat on the input stream after a random idle gap and returns
  // at the edge where it is accepted. The valid is only lowered when a gap is
  // drawn, so back-to-back beats keep it high without a glitch.
  task automatic offer_beat(input logic [SB-1:0] ph, input logic [SB-1:0] sh,
                            input logic [SB-1:0] md);
    int gap;
    gap = steady_run ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {md, sh, ph};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Stops offering and waits until every predicted sample has been returned.
  // The first edge lets the checker count a beat accepted at the last edge.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One random beat. Half are fully random; the rest aim at the mod and
  // shape extremes, the falling edge of the pulse, and the start of the
  // attack ramp, where the curve changes fastest.
  task automatic random_beat();
    logic [SB-1:0] ph, sh, md;
    int kind;
    int width_est;
    kind = $urandom_range(0, 9);
    ph = SB'($urandom);
    sh = SB'($urandom);
    md = SB'($urandom);
    case (kind)
      5, 6: begin
        case ($urandom_range(0, 4))
          0: md = 16'h8000;
          1: md = 16'h7fff;
          2: md = 16'h0000;
          3: md = 16'h0001;
          default: md = 16'hffff;
        endcase
      end
      7: begin
        sh = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      end
      8: begin
        width_est = 32768 + ($signed(sh) * WIDTH_GAIN) / 32768;
        if (width_est < WIDTH_MIN) width_est = WIDTH_MIN;
        if (width_est > WIDTH_MAX) width_est = WIDTH_MAX;
        width_est = width_est - 2 + $urandom_range(0, 4);
        ph = width_est[SB-1:0];
      end
      9: begin
        ph = SB'($urandom_range(0, 2047));
      end
      default: begin
      end
    endcase
    offer_beat(ph, sh, md);
  endtask

  // Receiver: a random stall before each result, plus one long stall on
  // request while the sender keeps pushing, so the pipeline fills and the
  // block has to drop in_tready.
  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = steady_run ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Sender and verdict.
  initial begin : beat_source
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    rst_n          = 1'b0;
    steady_run     = 1'b0;
    hold_off_req   = 1'b0;
    beats_sent     = 0;
    directed_beats = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero mod gives a hard gate: +1 inside the pulse, -1 at and past the
    // width, which is exactly one half for zero shape.
    offer_beat(16'd0,     16'd0, 16'd0);
    offer_beat(16'd65535, 16'd0, 16'd0);
    offer_beat(16'd32767, 16'd0, 16'd0);
    offer_beat(16'd32768, 16'd0, 16'd0);
    // Most negative shape lands right on the lower width clamp.
    offer_beat(16'd0,     16'h8000, 16'd0);
    offer_beat(16'd1310,  16'h8000, 16'd0);
    offer_beat(16'd1311,  16'h8000, 16'd0);
    // Most positive shape: the widest pulse the input can reach.
    offer_beat(16'd64223, 16'h7fff, 16'd0);
    offer_beat(16'd64224, 16'h7fff, 16'd0);
    // Mod at minus one is a pure decay over the whole pulse; its first
    // point is the peak, which saturates.
    offer_beat(16'd0,     16'd0, 16'h8000);
    offer_beat(16'd16000, 16'd0, 16'h8000);
    offer_beat(16'd32767, 16'd0, 16'h8000);
    // Mod just under plus one is almost a pure attack, starting at -1.
    offer_beat(16'd0,     16'd0, 16'h7fff);
    offer_beat(16'd16000, 16'd0, 16'h7fff);
    offer_beat(16'd32767, 16'd0, 16'h7fff);
    // The smallest mods leave an attack of zero length and a one-step decay.
    offer_beat(16'd0,     16'd0, 16'd1);
    offer_beat(16'd32767, 16'd0, 16'd1);
    offer_beat(16'd32767, 16'd0, 16'hffff);
    // Unequal ramps with a plateau between them.
    offer_beat(16'd10000, 16'd12345, 16'd16384);
    offer_beat(16'd30000, 16'd12345, 16'hc000);
    offer_beat(16'd22000, 16'd12345, 16'd16384);
    // All-ones on every field, then the most negative and most positive shape and mod.
    offer_beat(16'd65535, 16'hffff, 16'hffff);
    offer_beat(16'd0,     16'h8000, 16'h8000);
    offer_beat(16'd65535, 16'h7fff, 16'h7fff);
    directed_beats = beats_sent;
    wait_for_drain();

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // Idling is redrawn every hundred beats; some stretches run flat out.
      if (i % 100 == 0) steady_run = ($urandom_range(0, 2) == 0);
      if (i == 300) steady_run = 1'b1;
      // Long output stall while the input keeps coming without gaps.
      if (i == 500) begin
        hold_off_req = 1'b1;
        steady_run   = 1'b1;
      end
      if (i == 560) steady_run = 1'b0;
      // Full pause on the input until every result is back.
      if (i == 1000) wait_for_drain();
      random_beat();
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d beats sent (%0d directed), %0d samples compared",
             beats_sent, directed_beats, results_checked);
    $display("tb: covered gate, ramp, clamp and saturation cases, a long output stall and a drain");
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #1000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
